// ===== src/sacar_pkg.sv =====
// shared constants and types for the set-associative cache aging replacement unit
`timescale 1ns / 1ps

package sacar_pkg;

  localparam int ADDR_W     = 32;
  localparam int AGE_W      = 8;
  localparam int CNT_W      = 32;
  localparam int WAY_USED_W = 2;
  localparam int SET_USED_W = 6;

  localparam logic [AGE_W-1:0] FILL_MARK = 8'hF0;
  // padding ways in the victim tree never beat a real way
  localparam logic [AGE_W-1:0] AGE_PAD   = 8'hFF;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EVAL  = 3'b100
  } back_state_t;

  // back end to front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

// ===== src/sacar_front.sv =====
// front end: address split into tag and set, and a two-entry request queue
`timescale 1ns / 1ps

module sacar_front import sacar_pkg::*; #(
  parameter int OFFSET_BITS = 6,
  parameter int INDEX_BITS  = 6,
  localparam int TAG_W = ADDR_W - OFFSET_BITS - INDEX_BITS,
  localparam int SET_W = (INDEX_BITS > 0) ? INDEX_BITS : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ADDR_W-1:0] phys_addr,
  input  back_ctl_t         ctl,
  output logic              q_valid,
  output logic [TAG_W-1:0]  q_tag,
  output logic [SET_W-1:0]  q_set
);

  localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'((64'd1 << INDEX_BITS) - 64'd1);
  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  logic [TAG_W-1:0] tag_mem [2];
  logic [SET_W-1:0] set_mem [2];
  logic             wr_ptr, wr_ptr_next;
  logic             rd_ptr, rd_ptr_next;
  logic [1:0]       count, count_next;
  logic             push;
  logic [TAG_W-1:0] in_tag;
  logic [SET_W-1:0] in_set;

  assign in_tag   = TAG_W'(phys_addr >> (OFFSET_BITS + INDEX_BITS));
  assign in_set   = SET_W'((phys_addr >> OFFSET_BITS) & SET_MASK);

  // no transaction taken while the tag store is being cleared
  assign in_ready = (count != QUEUE_DEPTH) && !ctl.clearing;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_tag    = tag_mem[rd_ptr];
  assign q_set    = set_mem[rd_ptr];

  always_comb begin
    wr_ptr_next = push ? wr_ptr + 1'b1 : wr_ptr;
    rd_ptr_next = ctl.pop ? rd_ptr + 1'b1 : rd_ptr;
    count_next  = count + 2'(push) - 2'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      tag_mem[wr_ptr] <= in_tag;
      set_mem[wr_ptr] <= in_set;
    end
  end

endmodule

// ===== src/sacar_back.sv =====
// back end: set row memory, hit check, aging victim choice, counters, result register
`timescale 1ns / 1ps

module sacar_back import sacar_pkg::*; #(
  parameter int OFFSET_BITS = 6,
  parameter int INDEX_BITS  = 6,
  parameter int NUM_WAYS    = 4,
  localparam int TAG_W = ADDR_W - OFFSET_BITS - INDEX_BITS,
  localparam int SET_W = (INDEX_BITS > 0) ? INDEX_BITS : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  logic [TAG_W-1:0]      q_tag,
  input  logic [SET_W-1:0]      q_set,
  output back_ctl_t             ctl,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [WAY_USED_W-1:0] way_used,
  output logic [SET_USED_W-1:0] set_used,
  output logic [CNT_W-1:0]      hits_so_far,
  output logic [CNT_W-1:0]      misses_so_far,
  output logic [CNT_W-1:0]      accesses_so_far
);

  localparam int SETS    = 1 << INDEX_BITS;
  localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int WAYS_P2 = 1 << WAY_W;
  localparam int LINE_W  = 1 + TAG_W + AGE_W;
  localparam int ROW_W   = NUM_WAYS * LINE_W;
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

  logic [ROW_W-1:0] mem [SETS];
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wr_row;
  logic             rd_en, wr_en;
  logic [SET_W-1:0] wr_addr;

  back_state_t      state, state_next;
  logic [SET_W-1:0] clr_idx, clr_idx_next;
  logic [TAG_W-1:0] cur_tag;
  logic [SET_W-1:0] cur_set;
  logic [CNT_W-1:0] hit_cnt, miss_cnt, acc_cnt;
  logic             out_free, retire;

  logic             way_valid [NUM_WAYS];
  logic [TAG_W-1:0] way_tag   [NUM_WAYS];
  logic [AGE_W-1:0] way_age   [NUM_WAYS];
  logic [NUM_WAYS-1:0] match;
  logic             is_hit;
  logic [WAY_W-1:0] hit_way, victim, chosen;
  logic [AGE_W-1:0] lvl_age [WAY_W+1][WAYS_P2];
  logic [WAY_W-1:0] lvl_idx [WAY_W+1][WAYS_P2];
  logic [ROW_W-1:0] new_row;

  assign out_free     = !out_valid || out_ready;
  assign retire       = (state == ST_EVAL) && out_free;
  assign ctl.clearing = (state == ST_CLEAR);
  assign ctl.pop      = (state == ST_IDLE) && q_valid;
  assign rd_en        = ctl.pop;

  // unpack the registered set row and look for the tag
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      way_age[w]   = rd_row[w*LINE_W +: AGE_W];
      way_tag[w]   = rd_row[w*LINE_W + AGE_W +: TAG_W];
      way_valid[w] = rd_row[w*LINE_W + AGE_W + TAG_W];
      match[w]     = way_valid[w] && (way_tag[w] == cur_tag);
    end
    is_hit  = |match;
    hit_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
    end
  end

  // min-age tournament, right side wins only when strictly younger
  always_comb begin
    for (int l = 0; l <= WAY_W; l++) begin
      for (int i = 0; i < WAYS_P2; i++) begin
        lvl_age[l][i] = AGE_PAD;
        lvl_idx[l][i] = '0;
      end
    end
    for (int i = 0; i < NUM_WAYS; i++) begin
      lvl_age[0][i] = way_age[i];
      lvl_idx[0][i] = WAY_W'(i);
    end
    for (int l = 0; l < WAY_W; l++) begin
      for (int i = 0; i < (WAYS_P2 >> (l + 1)); i++) begin
        if (lvl_age[l][2*i+1] < lvl_age[l][2*i]) begin
          lvl_age[l+1][i] = lvl_age[l][2*i+1];
          lvl_idx[l+1][i] = lvl_idx[l][2*i+1];
        end else begin
          lvl_age[l+1][i] = lvl_age[l][2*i];
          lvl_idx[l+1][i] = lvl_idx[l][2*i];
        end
      end
    end
    victim = lvl_idx[WAY_W][0];
    chosen = is_hit ? hit_way : victim;
  end

  // miss fill: every age halves, victim gets the fill mark and the new tag
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WAY_W'(w) == victim) begin
        new_row[w*LINE_W +: LINE_W] = {1'b1, cur_tag, (way_age[w] >> 1) | FILL_MARK};
      end else begin
        new_row[w*LINE_W +: LINE_W] = {way_valid[w], way_tag[w], way_age[w] >> 1};
      end
    end
  end

  always_comb begin
    state_next   = state;
    clr_idx_next = clr_idx;
    wr_en        = 1'b0;
    wr_addr      = cur_set;
    wr_row       = new_row;
    unique case (state)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_idx;
        wr_row       = '0;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == LAST_SET) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          wr_en      = !is_hit;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      acc_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      if (retire) begin
        acc_cnt   <= acc_cnt + 1'b1;
        hit_cnt   <= hit_cnt + CNT_W'(is_hit);
        miss_cnt  <= miss_cnt + CNT_W'(!is_hit);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      cur_tag <= q_tag;
      cur_set <= q_set;
    end
    if (retire) begin
      hit             <= is_hit;
      way_used        <= WAY_USED_W'(chosen);
      set_used        <= SET_USED_W'(cur_set);
      hits_so_far     <= hit_cnt + CNT_W'(is_hit);
      misses_so_far   <= miss_cnt + CNT_W'(!is_hit);
      accesses_so_far <= acc_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[q_set];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

endmodule

// ===== src/set_assoc_cache_aging_replacement_unit.sv =====
// top level of the set-associative cache tag model with aging replacement
//
//   channel   handshake               payload
//   input     in_valid / in_ready     phys_addr
//   output    out_valid / out_ready   hit, way_used, set_used,
//                                     hits_so_far, misses_so_far, accesses_so_far
//
// each access passes through the back-end states ST_IDLE, which reads the set row from the
// row memory, and ST_EVAL, which checks tags, picks the victim and writes the row back
// the address is queued, the set row is registered, and then the result register is loaded
// after reset a clearing pass zeroes the row memory, one set per cycle, over all
// 2**INDEX_BITS sets, with in_ready low throughout
// a two-entry queue keeps accepting addresses, until it is full, while a result waits on out_ready
`timescale 1ns / 1ps

module set_assoc_cache_aging_replacement_unit import sacar_pkg::*; #(
  parameter int OFFSET_BITS = 6,
  parameter int INDEX_BITS  = 6,
  parameter int NUM_WAYS    = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADDR_W-1:0]     phys_addr,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [WAY_USED_W-1:0] way_used,
  output logic [SET_USED_W-1:0] set_used,
  output logic [CNT_W-1:0]      hits_so_far,
  output logic [CNT_W-1:0]      misses_so_far,
  output logic [CNT_W-1:0]      accesses_so_far
);

  localparam int TAG_W = ADDR_W - OFFSET_BITS - INDEX_BITS;
  localparam int SET_W = (INDEX_BITS > 0) ? INDEX_BITS : 1;

  back_ctl_t        ctl;
  logic             q_valid;
  logic [TAG_W-1:0] q_tag;
  logic [SET_W-1:0] q_set;

  sacar_front #(
    .OFFSET_BITS(OFFSET_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .phys_addr(phys_addr),
    .ctl      (ctl),
    .q_valid  (q_valid),
    .q_tag    (q_tag),
    .q_set    (q_set)
  );

  sacar_back #(
    .OFFSET_BITS(OFFSET_BITS),
    .INDEX_BITS (INDEX_BITS),
    .NUM_WAYS   (NUM_WAYS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_tag          (q_tag),
    .q_set          (q_set),
    .ctl            (ctl),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .way_used       (way_used),
    .set_used       (set_used),
    .hits_so_far    (hits_so_far),
    .misses_so_far  (misses_so_far),
    .accesses_so_far(accesses_so_far)
  );

endmodule

// ===== dv/set_assoc_cache_aging_replacement_unit_tb.sv =====
// self-checking testbench for the set-associative cache tag unit with aging replacement
`timescale 1ns / 1ps

module set_assoc_cache_aging_replacement_unit_tb import sacar_pkg::*;;

  localparam int OFF_BITS = 6;
  localparam int IDX_BITS = 6;
  localparam int WAYS     = 4;
  localparam int SETS     = 1 << IDX_BITS;
  localparam int TAG_W    = ADDR_W - OFF_BITS - IDX_BITS;
  localparam int N_DIRECTED = 17;
  localparam int N_PHASES   = 5;

  typedef struct packed {
    logic                  hit;
    logic [WAY_USED_W-1:0] way;
    logic [SET_USED_W-1:0] set_idx;
    logic [CNT_W-1:0]      hits;
    logic [CNT_W-1:0]      misses;
    logic [CNT_W-1:0]      accesses;
  } lookup_result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              known;
    lookup_result_t    want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ADDR_W-1:0]     phys_addr = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  hit;
  logic [WAY_USED_W-1:0] way_used;
  logic [SET_USED_W-1:0] set_used;
  logic [CNT_W-1:0]      hits_so_far;
  logic [CNT_W-1:0]      misses_so_far;
  logic [CNT_W-1:0]      accesses_so_far;

  // shadow copy of the cache
  logic [TAG_W-1:0] tag_mem   [SETS][WAYS];
  logic             valid_mem [SETS][WAYS];
  logic [AGE_W-1:0] age_mem   [SETS][WAYS];
  logic [CNT_W-1:0] hit_total, miss_total, access_total;

  lookup_result_t result_q[$];
  stim_row_t      directed_rows [N_DIRECTED];
  int             mismatches = 0;
  int             send_idle_pct = 0;
  int             stall_pct = 0;
  int             hold_left = 0;

  int phase_send  [N_PHASES] = '{0, 84, 0, 11, 0};
  int phase_stall [N_PHASES] = '{0, 0, 84, 11, 0};
  int phase_items [N_PHASES] = '{500, 400, 400, 400, 230};

  set_assoc_cache_aging_replacement_unit #(
    .OFFSET_BITS(OFF_BITS),
    .INDEX_BITS (IDX_BITS),
    .NUM_WAYS   (WAYS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .phys_addr      (phys_addr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .way_used       (way_used),
    .set_used       (set_used),
    .hits_so_far    (hits_so_far),
    .misses_so_far  (misses_so_far),
    .accesses_so_far(accesses_so_far)
  );

  always #6 clk = ~clk;

  function automatic lookup_result_t cache_lookup(input logic [ADDR_W-1:0] addr);
    logic [TAG_W-1:0] want;
    logic [AGE_W-1:0] lowest;
    int unsigned      s;
    int unsigned      victim;
    bit               found;
    lookup_result_t   r;
    want   = addr[ADDR_W-1 -: TAG_W];
    s      = addr[OFF_BITS +: IDX_BITS];
    victim = 0;
    found  = 1'b0;
    access_total = access_total + 1;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && valid_mem[s][w] && tag_mem[s][w] == want) begin
        victim = w;
        found  = 1'b1;
      end
    end
    if (found) begin
      hit_total = hit_total + 1;
    end else begin
      miss_total = miss_total + 1;
      // victim is picked on the ages before the shift
      lowest = age_mem[s][0];
      for (int w = 0; w < WAYS; w++) begin
        if (age_mem[s][w] < lowest) begin
          lowest = age_mem[s][w];
          victim = w;
        end
        age_mem[s][w] = age_mem[s][w] >> 1;
      end
      age_mem[s][victim]   = age_mem[s][victim] | FILL_MARK;
      tag_mem[s][victim]   = want;
      valid_mem[s][victim] = 1'b1;
    end
    r.hit      = found;
    r.way      = WAY_USED_W'(victim);
    r.set_idx  = SET_USED_W'(s);
    r.hits     = hit_total;
    r.misses   = miss_total;
    r.accesses = access_total;
    return r;
  endfunction

  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic known,
                             input lookup_result_t typed);
    lookup_result_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    phys_addr <= addr;
    do @(posedge clk); while (!in_ready);
    predicted = cache_lookup(addr);
    result_q.push_back(known ? typed : predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // result side: check, then pick next ready
  initial begin
    lookup_result_t exp_res;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result transaction: hit %0d way %0d set %0d",
                 hit, way_used, set_used);
          mismatches++;
        end else begin
          exp_res = result_q.pop_front();
          if (hit !== exp_res.hit) begin
            $error("hit: expected %0d, got %0d", exp_res.hit, hit);
            mismatches++;
          end
          if (way_used !== exp_res.way) begin
            $error("way_used: expected %0d, got %0d", exp_res.way, way_used);
            mismatches++;
          end
          if (set_used !== exp_res.set_idx) begin
            $error("set_used: expected %0d, got %0d", exp_res.set_idx, set_used);
            mismatches++;
          end
          if (hits_so_far !== exp_res.hits) begin
            $error("hits_so_far: expected %0d, got %0d", exp_res.hits, hits_so_far);
            mismatches++;
          end
          if (misses_so_far !== exp_res.misses) begin
            $error("misses_so_far: expected %0d, got %0d", exp_res.misses, misses_so_far);
            mismatches++;
          end
          if (accesses_so_far !== exp_res.accesses) begin
            $error("accesses_so_far: expected %0d, got %0d",
                   exp_res.accesses, accesses_so_far);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] addr;
    logic [TAG_W-1:0]  tag_base;
    int unsigned       hot_sets [3];

    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        tag_mem[s][w]   = '0;
        valid_mem[s][w] = 1'b0;
        age_mem[s][w]   = '0;
      end
    end
    hit_total    = '0;
    miss_total   = '0;
    access_total = '0;

    //                   addr          known hit  way   set    hits    misses  accesses
    // tag zero on an empty set still misses, then the same line hits
    directed_rows[0]  = {32'h0000_0000, 1'b1, 1'b0, 2'd0, 6'd0,  32'd0, 32'd1, 32'd1};
    directed_rows[1]  = {32'h0000_003F, 1'b1, 1'b1, 2'd0, 6'd0,  32'd1, 32'd1, 32'd2};
    // all-ones address: top set, top tag
    directed_rows[2]  = {32'hFFFF_FFFF, 1'b1, 1'b0, 2'd0, 6'd63, 32'd1, 32'd2, 32'd3};
    directed_rows[3]  = {32'hFFFF_FFC0, 1'b1, 1'b1, 2'd0, 6'd63, 32'd2, 32'd2, 32'd4};
    directed_rows[4]  = {32'h0000_0080, 1'b1, 1'b0, 2'd0, 6'd2,  32'd2, 32'd3, 32'd5};
    // fill set 1, then three evictions driven by the aged ages
    directed_rows[5]  = {32'h0000_1040, 1'b0, 105'd0};
    directed_rows[6]  = {32'h0000_2040, 1'b0, 105'd0};
    directed_rows[7]  = {32'h0000_3040, 1'b0, 105'd0};
    directed_rows[8]  = {32'h0000_4040, 1'b0, 105'd0};
    directed_rows[9]  = {32'h0000_5040, 1'b0, 105'd0};
    directed_rows[10] = {32'h0000_6040, 1'b0, 105'd0};
    directed_rows[11] = {32'h0000_3040, 1'b0, 105'd0};
    directed_rows[12] = {32'h0000_1040, 1'b0, 105'd0};
    directed_rows[13] = {32'hAAAA_AA80, 1'b0, 105'd0};
    directed_rows[14] = {32'h5555_5540, 1'b0, 105'd0};
    directed_rows[15] = {32'h8000_0000, 1'b0, 105'd0};
    directed_rows[16] = {32'h0000_0FC0, 1'b0, 105'd0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      send_access(directed_rows[i].addr, directed_rows[i].known, directed_rows[i].want);
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      send_idle_pct = phase_send[p];
      stall_pct     = phase_stall[p];
      tag_base      = TAG_W'($urandom);
      for (int k = 0; k < 3; k++) hot_sets[k] = $urandom_range(SETS - 1);
      // last phase: receiver stops long enough for the queue to back up
      if (p == N_PHASES - 1) hold_left = 120;
      for (int i = 0; i < phase_items[p]; i++) begin
        if ($urandom_range(99) < 75) begin
          // six tags over four ways in a few hot sets: hits, fills and evictions
          addr = {tag_base ^ TAG_W'($urandom_range(5)),
                  IDX_BITS'(hot_sets[$urandom_range(2)]),
                  OFF_BITS'($urandom_range((1 << OFF_BITS) - 1))};
        end else begin
          addr = $urandom;
        end
        send_access(addr, 1'b0, '0);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
